// ===== hdl/multi_pipe_byte_fifo_pool_unit_assert.svh =====
// Assertion macros for the pipe pool
`ifndef MULTI_PIPE_BYTE_FIFO_POOL_UNIT_ASSERT_SVH
`define MULTI_PIPE_BYTE_FIFO_POOL_UNIT_ASSERT_SVH

// same-cycle implication
`define MPBFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pipe pool check failed");

// next-cycle implication
`define MPBFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pipe pool check failed");

`endif

// ===== hdl/mpbfp_pkg.sv =====
package mpbfp_pkg;

    localparam int CHANNELS_DEF     = 32;
    localparam int BUFFER_BYTES_DEF = 256;

    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd256;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FREE  = 3'd1;
    localparam logic [2:0] ST_NOT_OPEN = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 32;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } mpbfp_cmd_t;

endpackage

// ===== hdl/multi_pipe_byte_fifo_pool_unit.sv =====
// Pool of byte pipes, each one a ring buffer of BUFFER_BYTES bytes.
// Input channel s_*: one item is one operation (create, write byte, read byte,
// close); s_tlast marks the last byte item of a multi-byte call.
// Result channel m_*: exactly one result item per input item, in order,
// carrying status, created pipe index, popped byte and the running byte count.
// Each item is captured, then executed (pipe update with byte store access),
// then loaded into the output register once that register is free.
// A new item is taken only after the previous one has executed, as set by the
// read-modify-write of the addressed pipe's pointers and the single-port byte store.
// The next item is taken while a result still waits in the output register;
// if the receiver holds m_tready low, the block stalls after finishing that
// next item, until the output register frees.
// Reset (aresetn low, synchronous): all pipes closed, pointers, fill counts and
// the byte counter cleared. The byte store itself is not cleared and needs no
// clearing pass, so items are accepted as soon as reset is released.
module multi_pipe_byte_fifo_pool_unit #(
    parameter int CHANNELS     = mpbfp_pkg::CHANNELS_DEF,
    parameter int BUFFER_BYTES = mpbfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode, pipe_index, write_byte, reader_id, writer_id
    input  logic [mpbfp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, created_index, read_byte, transfer_count
    output logic [mpbfp_pkg::M_DATA_W-1:0]  m_tdata
);
    import mpbfp_pkg::*;

    `include "multi_pipe_byte_fifo_pool_unit_assert.svh"

    mpbfp_cmd_t cmd;

    mpbfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mpbfp_datapath #(
        .CHANNELS     (CHANNELS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata)
    );

    `MPBFP_ASSERT_NEXT(a_accept_execs, s_tvalid && s_tready, cmd.exec && !s_tready)
    `MPBFP_ASSERT_NEXT(a_load_gives_valid, cmd.load_out, m_tvalid)
    `MPBFP_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= ST_EMPTY)

endmodule

// ===== hdl/mpbfp_ctrl.sv =====
module mpbfp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output mpbfp_pkg::mpbfp_cmd_t  cmd
);
    import mpbfp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.capture  = accept;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)  m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hdl/mpbfp_datapath.sv =====
module mpbfp_datapath #(
    parameter int CHANNELS     = mpbfp_pkg::CHANNELS_DEF,
    parameter int BUFFER_BYTES = mpbfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mpbfp_pkg::mpbfp_cmd_t            cmd,
    input  logic [mpbfp_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic [mpbfp_pkg::M_DATA_W-1:0]   m_tdata
);
    import mpbfp_pkg::*;

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = $clog2(BUFFER_BYTES);
    localparam int FW    = $clog2(BUFFER_BYTES + 1);
    localparam int DEPTH = CHANNELS * BUFFER_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [FW-1:0] FILL_FULL = FW'(BUFFER_BYTES);
    localparam logic [PW-1:0] PTR_LAST  = PW'(BUFFER_BYTES - 1);
    localparam logic [AW-1:0] BASE_STEP = AW'(BUFFER_BYTES);
    localparam logic [6:0]    CHAN_LIM  = 7'(CHANNELS);

    // captured item (owner ids are not retained)
    logic [1:0] mode_reg;
    logic [4:0] idx_reg;
    logic [7:0] wbyte_reg;
    logic       last_reg;

    logic [CHANNELS-1:0] open_reg;
    logic [PW-1:0]       rp_reg   [CHANNELS];
    logic [PW-1:0]       wp_reg   [CHANNELS];
    logic [FW-1:0]       fill_reg [CHANNELS];
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [CW-1:0] free_idx_reg, free_idx_next;
    logic          free_any_reg, free_any_next;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q_reg;

    logic [2:0]       res_status_reg, res_status_next;
    logic [4:0]       res_created_reg, res_created_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;
    logic             rd_ok_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [6:0]       idx7;
    logic             in_range;
    logic [CW-1:0]    cidx;
    logic             open_c;
    logic [PW-1:0]    rp_c, wp_c, ptr_c, ptr_adv;
    logic [FW-1:0]    fill_c;
    logic             is_write, is_read;
    logic             wr_ok, rd_ok;
    logic [CNT_W-1:0] cnt_inc;
    logic [AW-1:0]    addr;

    // lowest closed pipe, registered; open flags only move at the end of an exec cycle
    always_comb begin
        free_any_next = 1'b0;
        free_idx_next = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!open_reg[i]) begin
                free_any_next = 1'b1;
                free_idx_next = CW'(i);
            end
        end
    end

    assign idx7     = 7'(idx_reg);
    assign in_range = idx7 < CHAN_LIM;
    assign cidx     = idx7[CW-1:0];
    assign open_c   = in_range && open_reg[cidx];
    assign rp_c     = rp_reg[cidx];
    assign wp_c     = wp_reg[cidx];
    assign fill_c   = fill_reg[cidx];
    assign is_write = (mode_reg == MODE_WRITE);
    assign is_read  = (mode_reg == MODE_READ);
    assign wr_ok    = open_c && is_write && (fill_c != FILL_FULL);
    assign rd_ok    = open_c && is_read && (fill_c != '0);
    assign cnt_inc  = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign ptr_c    = is_write ? wp_c : rp_c;
    assign ptr_adv  = (ptr_c == PTR_LAST) ? '0 : ptr_c + 1'b1;
    assign addr     = AW'(cidx) * BASE_STEP + AW'(ptr_c);

    always_comb begin
        res_status_next  = ST_OK;
        res_created_next = '0;
        res_count_next   = '0;
        cnt_next         = cnt_reg;
        unique case (mode_reg) inside
            MODE_CREATE: begin
                cnt_next = '0;
                if (free_any_reg) res_created_next = 5'(free_idx_reg);
                else              res_status_next  = ST_NO_FREE;
            end
            MODE_CLOSE: begin
                cnt_next = '0;
            end
            MODE_WRITE, MODE_READ: begin
                if (!open_c)               res_status_next = ST_NOT_OPEN;
                else if (is_write && !wr_ok) res_status_next = ST_FULL;
                else if (is_read && !rd_ok)  res_status_next = ST_EMPTY;
                res_count_next = (wr_ok || rd_ok) ? cnt_inc : cnt_reg;
                cnt_next       = last_reg ? '0 : res_count_next;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_tdata[1:0];
            idx_reg   <= s_tdata[6:2];
            wbyte_reg <= s_tdata[14:7];
            last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg     <= '0;
            cnt_reg      <= '0;
            free_any_reg <= 1'b1;
            free_idx_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            free_any_reg <= free_any_next;
            free_idx_reg <= free_idx_next;
            if (cmd.exec) begin
                cnt_reg <= cnt_next;
                if (mode_reg == MODE_CREATE && free_any_reg) begin
                    open_reg[free_idx_reg] <= 1'b1;
                    rp_reg[free_idx_reg]   <= '0;
                    wp_reg[free_idx_reg]   <= '0;
                    fill_reg[free_idx_reg] <= '0;
                end
                if (mode_reg == MODE_CLOSE && in_range) open_reg[cidx] <= 1'b0;
                if (wr_ok) begin
                    wp_reg[cidx]   <= ptr_adv;
                    fill_reg[cidx] <= fill_c + 1'b1;
                end
                if (rd_ok) begin
                    rp_reg[cidx]   <= ptr_adv;
                    fill_reg[cidx] <= fill_c - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (wr_ok) mem[addr] <= wbyte_reg;
            mem_q_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg  <= res_status_next;
            res_created_reg <= res_created_next;
            res_count_reg   <= res_count_next;
            rd_ok_reg       <= rd_ok;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {7'd0, res_count_reg, (rd_ok_reg ? mem_q_reg : 8'd0),
                            res_created_reg, res_status_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule
